// ===== rtl/core/varint_zigzag_decoder_assert.svh =====
// Assertion macros for the varint zigzag decoder checker.
// Needs no package; the including file supplies clock, reset and expressions.
`ifndef VARINT_ZIGZAG_DECODER_ASSERT_SVH
`define VARINT_ZIGZAG_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define VZD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define VZD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/vzd_pkg.sv =====
// Shared types and constants for the varint zigzag decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package vzd_pkg;

	localparam int BITS_PER_BYTE       = 7;
	localparam int MAX_BYTES           = 10;
	localparam int QUEUE_DEPTH_DEFAULT = 2;

	localparam logic [7:0] PAYLOAD_MASK   = 8'h7F;
	localparam int         MORE_BIT       = 7;
	localparam logic [3:0] COUNT_TOO_LONG = 4'd11;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
	localparam logic [1:0] STATUS_TOO_BIG  = 2'd2;

	typedef enum logic [1:0] {
		KIND_U64 = 2'd0,
		KIND_U32 = 2'd1,
		KIND_S32 = 2'd2,
		KIND_S64 = 2'd3
	} kind_t;

	// One finished varint as handed from the front end to the back end
	typedef struct packed {
		logic [63:0] acc;
		logic [3:0]  count;
		logic        too_long;
		kind_t       kind;
	} vzd_rec_t;

	typedef struct packed {
		logic     valid;
		vzd_rec_t rec;
	} vzd_slot_t;

endpackage

// ===== rtl/core/vzd_front.sv =====
// Front end: takes bytes, assembles varints, tracks discarding and the kind register.
// Depends on vzd_pkg; pushes finished varints into vzd_queue.
`timescale 1ns / 1ps

module vzd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_wdata,
	input  logic              q_full,
	output vzd_pkg::vzd_slot_t push
);
	import vzd_pkg::*;

	logic [63:0] acc_q, acc_d, acc_new, payload_sh;
	logic [3:0]  bytes_q, bytes_d, bytes_inc;
	logic        disc_q, disc_d;
	kind_t       kind_q;
	logic [6:0]  shamt;
	logic        accept, more;

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign more      = data_byte[MORE_BIT];
	assign bytes_inc = bytes_q + 4'd1;
	assign shamt     = 7'(bytes_q) * 7'(BITS_PER_BYTE);
	// payload bits shifted beyond bit 63 fall off here
	assign payload_sh = 64'(data_byte & PAYLOAD_MASK) << shamt;
	assign acc_new    = acc_q | payload_sh;

	always_comb begin
		acc_d          = acc_q;
		bytes_d        = bytes_q;
		disc_d         = disc_q;
		push.valid     = 1'b0;
		push.rec.acc   = acc_new;
		push.rec.count = bytes_inc;
		push.rec.too_long = 1'b0;
		push.rec.kind  = kind_q;
		if (accept) begin
			if (disc_q) begin
				if (!more) begin
					disc_d = 1'b0;
				end
			end else if (bytes_q >= 4'(MAX_BYTES)) begin
				push.valid        = 1'b1;
				push.rec.acc      = '0;
				push.rec.count    = COUNT_TOO_LONG;
				push.rec.too_long = 1'b1;
				acc_d             = '0;
				bytes_d           = '0;
				disc_d            = more;
			end else if (more) begin
				acc_d   = acc_new;
				bytes_d = bytes_inc;
			end else begin
				push.valid = 1'b1;
				acc_d      = '0;
				bytes_d    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			bytes_q <= '0;
			disc_q  <= 1'b0;
			kind_q  <= KIND_U64;
		end else begin
			acc_q   <= acc_d;
			bytes_q <= bytes_d;
			disc_q  <= disc_d;
			if (cfg_we) begin
				kind_q <= kind_t'(cfg_wdata);
			end
		end
	end

endmodule

// ===== rtl/core/vzd_queue.sv =====
// Short queue of finished varints between the front and back ends.
// Depends on vzd_pkg for the record type.
`timescale 1ns / 1ps

module vzd_queue #(
	parameter int DEPTH = vzd_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vzd_pkg::vzd_slot_t push,
	output logic               full,
	input  logic               pop,
	output vzd_pkg::vzd_slot_t head
);
	import vzd_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	vzd_rec_t          mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.rec   = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/vzd_back.sv =====
// Back end: range checks, zigzag decoding and the output register.
// Depends on vzd_pkg; pops finished varints from vzd_queue.
`timescale 1ns / 1ps

module vzd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  vzd_pkg::vzd_slot_t head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [63:0]        decoded_value,
	output logic [3:0]         byte_count,
	output logic [1:0]         status
);
	import vzd_pkg::*;

	logic        out_valid_q;
	logic [63:0] value_q, res_value, z64;
	logic [3:0]  count_q;
	logic [1:0]  status_q, res_status;
	logic [31:0] z32;
	logic        is32;

	assign pop = head.valid && (!out_valid_q || out_ready);

	assign z32  = {1'b0, head.rec.acc[31:1]} ^ {32{head.rec.acc[0]}};
	assign z64  = {1'b0, head.rec.acc[63:1]} ^ {64{head.rec.acc[0]}};
	assign is32 = (head.rec.kind == KIND_U32) || (head.rec.kind == KIND_S32);

	always_comb begin
		res_value  = '0;
		res_status = STATUS_OK;
		if (head.rec.too_long) begin
			res_status = STATUS_TOO_LONG;
		end else if (is32 && (head.rec.acc[63:32] != '0)) begin
			res_status = STATUS_TOO_BIG;
		end else begin
			unique case (head.rec.kind) inside
				KIND_U64, KIND_U32: res_value = head.rec.acc;
				KIND_S32:           res_value = {{32{z32[31]}}, z32};
				KIND_S64:           res_value = z64;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (pop) begin
			value_q  <= res_value;
			count_q  <= head.rec.count;
			status_q <= res_status;
		end
	end

	assign out_valid     = out_valid_q;
	assign decoded_value = value_q;
	assign byte_count    = count_q;
	assign status        = status_q;

endmodule

// ===== rtl/core/varint_zigzag_decoder.sv =====
// Varint (LEB128) decoder with zigzag for signed kinds; top level.
// A finished varint is written into the result queue and from there into the output register.
// Throughput: one byte per cycle; in_ready drops only when the result queue is full.
// Reset (arst_n low): clears the partial varint, discarding state, queue and kind (to U64).
// Instantiates vzd_front, vzd_queue and vzd_back; uses vzd_pkg.
`timescale 1ns / 1ps

module varint_zigzag_decoder #(
	parameter int QUEUE_DEPTH = vzd_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] decoded_value,
	output logic [3:0]  byte_count,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata
);
	import vzd_pkg::*;

	vzd_slot_t push, head;
	logic      q_full, pop;

	vzd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (push)
	);

	vzd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.head   (head)
	);

	vzd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.decoded_value (decoded_value),
		.byte_count    (byte_count),
		.status        (status)
	);

endmodule

// ===== rtl/core/vzd_checker.sv =====
// Port-level checks on the varint zigzag decoder, bound to the top level.
// Depends on vzd_pkg and varint_zigzag_decoder_assert.svh.
`timescale 1ns / 1ps
`include "varint_zigzag_decoder_assert.svh"

module vzd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] decoded_value,
	input logic [3:0]  byte_count,
	input logic [1:0]  status
);
	import vzd_pkg::*;

	// a stalled transaction keeps its payload
	`VZD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(decoded_value) && $stable(byte_count) && $stable(status),
		"stalled result changed")
	`VZD_ASSERT_NOW(a_count_range, clk, arst_n, out_valid,
		byte_count != 4'd0 && byte_count <= COUNT_TOO_LONG && status != 2'd3,
		"byte count or status out of range")
	`VZD_ASSERT_NOW(a_too_long, clk, arst_n, out_valid && status == STATUS_TOO_LONG,
		byte_count == COUNT_TOO_LONG && decoded_value == '0,
		"bad too-long result")
	`VZD_ASSERT_NOW(a_too_big, clk, arst_n, out_valid && status == STATUS_TOO_BIG,
		decoded_value == '0 && byte_count >= 4'd5 && byte_count <= 4'd10,
		"bad too-big result")
	`VZD_ASSERT_NOW(a_ok_len, clk, arst_n, out_valid && status == STATUS_OK,
		byte_count <= 4'd10, "ok result longer than ten bytes")

endmodule

bind varint_zigzag_decoder vzd_checker u_vzd_checker (.*);

// ===== dv/varint_zigzag_decoder_tb.sv =====
// Self-checking testbench for varint_zigzag_decoder: directed and random byte streams.
// Predicts each decoded varint in-line and checks results in order.
// Depends on vzd_pkg and the varint_zigzag_decoder RTL.
`timescale 1ns / 1ps

module varint_zigzag_decoder_tb;
	import vzd_pkg::*;

	typedef struct {
		logic [63:0] value;
		logic [3:0]  count;
		logic [1:0]  st;
	} varint_result_t;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_BURSTY, RX_STARVED} rx_pattern_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] decoded_value;
	logic [3:0]  byte_count;
	logic [1:0]  status;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_wdata = 2'd0;

	// Decoder state as predicted by the testbench
	logic [63:0] acc_bits;
	logic [3:0]  acc_bytes;
	logic        skipping;
	kind_t       active_kind;

	varint_result_t expected_varints[$];
	varint_result_t want;
	int          error_count = 0;
	int          bytes_sent = 0;
	int          burst_left = 0;
	int          stall_left = 0;
	bit          tx_gappy = 1'b0;
	rx_pattern_t rx_mode = RX_ALWAYS;

	varint_zigzag_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.decoded_value(decoded_value),
		.byte_count(byte_count),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic void predict_decode(input logic [7:0] b);
		varint_result_t r;
		logic [31:0] lo;
		logic [31:0] z32;
		if (skipping) begin
			if (!b[MORE_BIT])
				skipping = 1'b0;
			return;
		end
		if (acc_bytes >= MAX_BYTES) begin
			r.value = 64'd0;
			r.count = COUNT_TOO_LONG;
			r.st = STATUS_TOO_LONG;
			expected_varints.push_back(r);
			acc_bits = 64'd0;
			acc_bytes = 4'd0;
			skipping = b[MORE_BIT];
			return;
		end
		// bits shifted past position 63 fall off the top
		acc_bits |= 64'(b & PAYLOAD_MASK) << (BITS_PER_BYTE * acc_bytes);
		acc_bytes++;
		if (b[MORE_BIT])
			return;
		r.count = acc_bytes;
		r.st = STATUS_OK;
		r.value = acc_bits;
		if ((active_kind == KIND_U32 || active_kind == KIND_S32) && acc_bits[63:32] != 32'd0) begin
			r.st = STATUS_TOO_BIG;
			r.value = 64'd0;
		end else if (active_kind == KIND_S32) begin
			lo = acc_bits[31:0];
			z32 = (lo >> 1) ^ {32{lo[0]}};
			r.value = {{32{z32[31]}}, z32};
		end else if (active_kind == KIND_S64) begin
			r.value = (acc_bits >> 1) ^ {64{acc_bits[0]}};
		end
		expected_varints.push_back(r);
		acc_bits = 64'd0;
		acc_bytes = 4'd0;
	endfunction

	// Receiver back-pressure
	always @(posedge clk) begin
		case (rx_mode)
			RX_ALWAYS: out_ready <= 1'b1;
			RX_COIN: out_ready <= 1'($urandom_range(0, 1));
			RX_BURSTY: begin
				if (stall_left != 0) begin
					stall_left--;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
					if ($urandom_range(0, 9) == 0)
						stall_left = $urandom_range(1, 12);
				end
			end
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_varints.size() == 0) begin
				$error("unexpected result: decoded_value %h byte_count %0d status %0d",
					decoded_value, byte_count, status);
				error_count++;
			end else begin
				want = expected_varints.pop_front();
				if (decoded_value !== want.value) begin
					$error("decoded_value: expected %h, got %h", want.value, decoded_value);
					error_count++;
				end
				if (byte_count !== want.count) begin
					$error("byte_count: expected %0d, got %0d", want.count, byte_count);
					error_count++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					error_count++;
				end
			end
		end
	end

	// Present one byte and hold it until the transaction completes
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (tx_gappy) begin
			if (burst_left == 0) begin
				gap = $urandom_range(0, 6);
				burst_left = $urandom_range(1, 12);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		predict_decode(b);
		bytes_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_varints.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_kind(input kind_t k);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_kind = k;
	endtask

	task automatic test_short_values();
		set_kind(KIND_U64);
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte(8'h80);
		send_byte(8'h01);
	endtask

	task automatic test_length_limit();
		// ten bytes of ones: the top payload bits drop off
		repeat (9) send_byte(8'hFF);
		send_byte(8'h7F);
		// too long, eleventh byte ends it
		repeat (10) send_byte(8'h80);
		send_byte(8'h00);
		// too long, then discard up to the next clear top bit
		repeat (11) send_byte(8'h80);
		send_byte(8'h81);
		send_byte(8'h05);
		send_byte(8'h05);
	endtask

	task automatic test_32bit_kinds();
		set_kind(KIND_U32);
		repeat (4) send_byte(8'hFF);
		send_byte(8'h0F);
		repeat (4) send_byte(8'h80);
		send_byte(8'h10);
		set_kind(KIND_S32);
		send_byte(8'h01);
		send_byte(8'hFE);
		repeat (3) send_byte(8'hFF);
		send_byte(8'h0F);
		repeat (4) send_byte(8'hFF);
		send_byte(8'h0F);
		repeat (4) send_byte(8'h80);
		send_byte(8'h10);
	endtask

	task automatic test_signed64();
		set_kind(KIND_S64);
		send_byte(8'h01);
		send_byte(8'h02);
		repeat (9) send_byte(8'hFF);
		send_byte(8'h01);
	endtask

	task automatic test_kind_change_mid_varint();
		send_byte(8'h81);
		set_kind(KIND_U64);
		send_byte(8'h01);
		send_byte(8'h83);
		set_kind(KIND_S32);
		send_byte(8'h00);
	endtask

	task automatic send_random_varint();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			send_byte(8'($urandom));
		end else if (pick < 14) begin
			n = $urandom_range(11, 14);
			repeat (n - 1) send_byte(8'h80 | 8'($urandom_range(0, 127)));
			send_byte(8'($urandom_range(0, 127)));
		end else begin
			n = (pick < 60) ? $urandom_range(1, 3) : $urandom_range(1, 10);
			repeat (n - 1) send_byte(8'h80 | 8'($urandom_range(0, 127)));
			// half the time, keep five-byte values near the 32-bit boundary
			if (n == 5 && $urandom_range(0, 1) == 1)
				send_byte(8'($urandom_range(0, 31)));
			else
				send_byte(8'($urandom_range(0, 127)));
		end
	endtask

	task automatic test_random_streams();
		kind_t order[8];
		int target;
		order = '{KIND_U64, KIND_S64, KIND_U32, KIND_S32, KIND_S64, KIND_U64, KIND_U32, KIND_S32};
		for (int i = 0; i < 8; i++) begin
			set_kind(order[i]);
			rx_mode = rx_pattern_t'(i % 4);
			tx_gappy = (i % 3) != 0;
			burst_left = 0;
			target = bytes_sent + 80;
			while (bytes_sent < target) send_random_varint();
		end
	endtask

	initial begin
		acc_bits = 64'd0;
		acc_bytes = 4'd0;
		skipping = 1'b0;
		active_kind = KIND_U64;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_values();
		test_length_limit();
		rx_mode = RX_BURSTY;
		tx_gappy = 1'b1;
		test_32bit_kinds();
		test_signed64();
		test_kind_change_mid_varint();
		test_random_streams();
		drain_results();
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/vzd_pkg.sv
rtl/core/vzd_front.sv
rtl/core/vzd_queue.sv
rtl/core/vzd_back.sv
rtl/core/varint_zigzag_decoder.sv
rtl/core/vzd_checker.sv
dv/varint_zigzag_decoder_tb.sv
